>>> src/lmh_pkg.sv
package lmh_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned BLOCK_BYTES = 32;
    localparam int unsigned LANES = 8;

    localparam logic [31:0] LANE_CONST [LANES] = '{
        32'd1, 32'd11, 32'd111, 32'd1111,
        32'd11111, 32'd111111, 32'd1111111, 32'd11111111
    };
    localparam logic [31:0] MIX_INIT   = 32'd1111111111;
    localparam logic [31:0] PRIOR_INIT = 32'd111111111;
    localparam logic [31:0] TAIL_CONST = 32'd1111111111;

    // work handed from the byte collector to the mixing engine
    typedef struct packed {
        logic         blk;     // full block to mix
        logic         fin;     // message ends, run finalization
        logic [255:0] data;    // byte i at bits 8i+7:8i
        logic [4:0]   fill;    // bytes left over at the end
        logic [31:0]  total;   // message length modulo 2^32
        logic         r16;
        logic         r32;
    } job_t;

    typedef enum logic [1:0] {
        OP_BLOCK,
        OP_CH16,
        OP_CH8
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM,
        ST_LANE,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_FA,
        ST_FB,
        ST_FC,
        ST_FD,
        ST_FE,
        ST_FF,
        ST_FG,
        ST_FH,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G4,
        ST_G5,
        ST_G6,
        ST_G7,
        ST_G8,
        ST_G9,
        ST_EMIT
    } st_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        return (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

>>> src/lmh_if.sv
interface lmh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface lmh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

>>> src/lmh_front.sv
module lmh_front (
    input  logic          clk,
    input  logic          rst_n,
    lmh_in_if.sink        byte_ch,
    input  logic          q_full,
    output logic          push,
    output lmh_pkg::job_t push_job
);

    logic [7:0]  buf_reg [lmh_pkg::BLOCK_BYTES];
    logic [4:0]  fill_reg;
    logic [31:0] total_reg;
    logic        r16_reg;
    logic        r32_reg;

    logic [4:0]   fill_next;
    logic [31:0]  total_next;
    logic         r16_next;
    logic         r32_next;
    logic         xfer;
    logic         full;
    logic [255:0] data_now;

    assign byte_ch.ready = !q_full;
    assign xfer = byte_ch.valid && byte_ch.ready;
    assign full = byte_ch.has_byte && (fill_reg == 5'd31);

    // block contents including the byte of this transfer
    always_comb
    begin
        for (int i = 0; i < lmh_pkg::BLOCK_BYTES; i++)
        begin
            if (byte_ch.has_byte && (fill_reg == 5'(i)))
                data_now[8*i +: 8] = byte_ch.data_byte;
            else
                data_now[8*i +: 8] = buf_reg[i];
        end
    end

    always_comb
    begin
        total_next = total_reg;
        r16_next   = r16_reg;
        r32_next   = r32_reg;
        fill_next  = fill_reg;
        if (byte_ch.has_byte)
        begin
            total_next = total_reg + 32'd1;
            r16_next   = r16_reg || (total_next >= 32'd16);
            r32_next   = r32_reg || (total_next >= 32'd32);
            fill_next  = fill_reg + 5'd1;
        end
    end

    assign push = xfer && (full || byte_ch.last);

    always_comb
    begin
        push_job.blk   = full;
        push_job.fin   = byte_ch.last;
        push_job.data  = data_now;
        push_job.fill  = fill_next;
        push_job.total = total_next;
        push_job.r16   = r16_next;
        push_job.r32   = r32_next;
    end

    always_ff @(posedge clk)
    begin
        if (xfer && byte_ch.has_byte)
            buf_reg[fill_reg] <= byte_ch.data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            r16_reg   <= 1'b0;
            r32_reg   <= 1'b0;
        end
        else if (xfer)
        begin
            if (byte_ch.last)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
                r16_reg   <= 1'b0;
                r32_reg   <= 1'b0;
            end
            else
            begin
                fill_reg  <= fill_next;
                total_reg <= total_next;
                r16_reg   <= r16_next;
                r32_reg   <= r32_next;
            end
        end
    end

    a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && byte_ch.last) |=> (fill_reg == '0 && total_reg == '0 && !r16_reg))
        else $error("collector state not cleared after message end");

endmodule

>>> src/lmh_queue.sv
module lmh_queue #(
    parameter int unsigned DEPTH = lmh_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lmh_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output lmh_pkg::job_t q_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lmh_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

>>> src/lmh_back.sv
module lmh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  lmh_pkg::job_t q_job,
    output logic          pop,
    lmh_out_if.source     hash_ch
);

    lmh_pkg::st_t state_reg, state_next;
    lmh_pkg::op_t op_reg, op_next;
    lmh_pkg::job_t job_reg;

    logic [31:0] lane_reg [lmh_pkg::LANES];
    logic [31:0] mix_reg;
    logic [31:0] prior_reg;
    logic [31:0] acc_reg;
    logic [2:0]  k_reg;
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic        emit_go;
    logic [2:0]  sum_last;
    logic [2:0]  lane_last;
    logic [2:0]  widx;
    logic [31:0] word_k;
    logic [31:0] sum_now;
    logic [31:0] lane_new;
    logic [4:0]  sel_fill;
    lmh_pkg::st_t tail_go;
    logic [2:0]  tail_t;
    logic [1:0]  tail_rest;
    logic [2:0]  tail_wp;
    logic [31:0] tail_w0;
    logic [31:0] tail_w1;
    logic [31:0] mask0;
    logic [31:0] mask1;

    function automatic logic [31:0] word_at(input logic [255:0] d, input logic [2:0] i);
        return d[{i, 5'b0} +: 32];
    endfunction

    function automatic logic [31:0] byte_mask(input logic [1:0] n);
        logic [31:0] m;
        case (n)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // per-op loop bounds
    always_comb
    begin
        case (op_reg)
            lmh_pkg::OP_BLOCK:
            begin
                sum_last  = 3'd7;
                lane_last = 3'd7;
                widx      = 3'd7 - k_reg;
            end
            lmh_pkg::OP_CH16:
            begin
                sum_last  = 3'd4;
                lane_last = 3'd3;
                widx      = k_reg;
            end
            lmh_pkg::OP_CH8:
            begin
                sum_last  = 3'd2;
                lane_last = 3'd1;
                widx      = {job_reg.fill[4], 2'b00} + k_reg;
            end
            default:
            begin
                sum_last  = 3'd7;
                lane_last = 3'd7;
                widx      = k_reg;
            end
        endcase
    end

    assign word_k   = word_at(job_reg.data, widx);
    assign sum_now  = acc_reg + lane_reg[k_reg];
    assign lane_new = lane_reg[k_reg] + word_k
                    + lmh_pkg::rotl32(lane_reg[k_reg], {2'b01, k_reg})
                    + prior_reg + lmh_pkg::LANE_CONST[k_reg];

    assign tail_t    = job_reg.fill[2:0];
    assign tail_rest = tail_t[1:0];
    assign tail_wp   = {job_reg.fill[4], job_reg.fill[3], 1'b0};
    assign tail_w0   = word_at(job_reg.data, tail_wp);
    assign tail_w1   = word_at(job_reg.data, tail_wp + 3'd1);
    assign mask0     = byte_mask(tail_rest);
    assign mask1     = byte_mask(tail_rest);

    assign sel_fill = (state_reg == lmh_pkg::ST_IDLE) ? q_job.fill : job_reg.fill;
    assign tail_go  = (sel_fill[2:0] != 3'd0) ? lmh_pkg::ST_T0 : lmh_pkg::ST_FA;

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            lmh_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_job.blk)
                    begin
                        state_next = lmh_pkg::ST_SUM;
                        op_next    = lmh_pkg::OP_BLOCK;
                    end
                    else if (q_job.fill[4])
                    begin
                        state_next = lmh_pkg::ST_SUM;
                        op_next    = lmh_pkg::OP_CH16;
                    end
                    else if (q_job.fill[3])
                    begin
                        state_next = lmh_pkg::ST_SUM;
                        op_next    = lmh_pkg::OP_CH8;
                    end
                    else
                        state_next = tail_go;
                end
            end
            lmh_pkg::ST_SUM:
            begin
                if (k_reg == sum_last)
                    state_next = lmh_pkg::ST_LANE;
            end
            lmh_pkg::ST_LANE:
            begin
                if (k_reg == lane_last)
                begin
                    case (op_reg)
                        lmh_pkg::OP_BLOCK:
                            state_next = job_reg.fin ? lmh_pkg::ST_FA : lmh_pkg::ST_IDLE;
                        lmh_pkg::OP_CH16:
                        begin
                            if (job_reg.fill[3])
                            begin
                                state_next = lmh_pkg::ST_SUM;
                                op_next    = lmh_pkg::OP_CH8;
                            end
                            else
                                state_next = tail_go;
                        end
                        default:
                            state_next = tail_go;
                    endcase
                end
            end
            lmh_pkg::ST_T0: state_next = lmh_pkg::ST_T1;
            lmh_pkg::ST_T1:
                state_next = (tail_t[2] && tail_t != 3'd4) ? lmh_pkg::ST_T2 : lmh_pkg::ST_FA;
            lmh_pkg::ST_T2: state_next = lmh_pkg::ST_T3;
            lmh_pkg::ST_T3: state_next = lmh_pkg::ST_T4;
            lmh_pkg::ST_T4: state_next = lmh_pkg::ST_FA;
            lmh_pkg::ST_FA: state_next = lmh_pkg::ST_FB;
            lmh_pkg::ST_FB: state_next = job_reg.r16 ? lmh_pkg::ST_FC : lmh_pkg::ST_G0;
            lmh_pkg::ST_FC: state_next = lmh_pkg::ST_FD;
            lmh_pkg::ST_FD: state_next = job_reg.r32 ? lmh_pkg::ST_FE : lmh_pkg::ST_G0;
            lmh_pkg::ST_FE: state_next = lmh_pkg::ST_FF;
            lmh_pkg::ST_FF: state_next = lmh_pkg::ST_FG;
            lmh_pkg::ST_FG: state_next = lmh_pkg::ST_FH;
            lmh_pkg::ST_FH: state_next = lmh_pkg::ST_G0;
            lmh_pkg::ST_G0: state_next = lmh_pkg::ST_G1;
            lmh_pkg::ST_G1: state_next = lmh_pkg::ST_G2;
            lmh_pkg::ST_G2: state_next = lmh_pkg::ST_G3;
            lmh_pkg::ST_G3: state_next = lmh_pkg::ST_G4;
            lmh_pkg::ST_G4: state_next = lmh_pkg::ST_G5;
            lmh_pkg::ST_G5: state_next = lmh_pkg::ST_G6;
            lmh_pkg::ST_G6: state_next = lmh_pkg::ST_G7;
            lmh_pkg::ST_G7: state_next = lmh_pkg::ST_G8;
            lmh_pkg::ST_G8: state_next = lmh_pkg::ST_G9;
            lmh_pkg::ST_G9: state_next = lmh_pkg::ST_EMIT;
            lmh_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || hash_ch.ready)
                    state_next = lmh_pkg::ST_IDLE;
            end
            default: state_next = lmh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop     = 1'b0;
        emit_go = 1'b0;
        case (state_reg)
            lmh_pkg::ST_IDLE: pop = q_valid;
            lmh_pkg::ST_EMIT: emit_go = !out_valid_reg || hash_ch.ready;
            default:
            begin
                pop     = 1'b0;
                emit_go = 1'b0;
            end
        endcase
    end

    assign hash_ch.valid      = out_valid_reg;
    assign hash_ch.hash_value = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmh_pkg::ST_IDLE;
            op_reg    <= lmh_pkg::OP_BLOCK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (emit_go)
            hash_reg <= (lane_reg[6] ^ lmh_pkg::rotl32(lane_reg[7], 5'd21))
                      + mix_reg + prior_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_go)
            out_valid_reg <= 1'b1;
        else if (hash_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // lanes, mixing words and loop counters; lanes a..h serve finalization
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmh_pkg::LANES; i++)
                lane_reg[i] <= lmh_pkg::LANE_CONST[i];
            mix_reg   <= lmh_pkg::MIX_INIT;
            prior_reg <= lmh_pkg::PRIOR_INIT;
            acc_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                lmh_pkg::ST_IDLE:
                begin
                    acc_reg <= '0;
                    k_reg   <= '0;
                end
                lmh_pkg::ST_SUM:
                begin
                    if (k_reg == sum_last)
                    begin
                        prior_reg <= (op_reg == lmh_pkg::OP_BLOCK) ? mix_reg
                                                                    : prior_reg + mix_reg;
                        mix_reg   <= mix_reg + sum_now;
                        acc_reg   <= '0;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        acc_reg <= sum_now;
                        k_reg   <= k_reg + 3'd1;
                    end
                end
                lmh_pkg::ST_LANE:
                begin
                    lane_reg[k_reg] <= lane_new;
                    if (k_reg == lane_last)
                    begin
                        if (op_reg == lmh_pkg::OP_BLOCK)
                            prior_reg <= prior_reg + acc_reg + lane_new;
                        acc_reg <= '0;
                        k_reg   <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + lane_new;
                        k_reg   <= k_reg + 3'd1;
                    end
                end
                lmh_pkg::ST_T0:
                    mix_reg <= mix_reg + lmh_pkg::rotl32(lane_reg[0], 5'd8) + prior_reg;
                lmh_pkg::ST_T1:
                begin
                    if (tail_t[2])
                        lane_reg[0] <= lane_reg[0] + tail_w0 + mix_reg + lmh_pkg::TAIL_CONST;
                    else
                        lane_reg[0] <= lane_reg[0] + (tail_w0 & mask0)
                                     + mix_reg + lmh_pkg::LANE_CONST[tail_t - 3'd1];
                end
                lmh_pkg::ST_T2:
                    prior_reg <= prior_reg + lane_reg[0] + lane_reg[1];
                lmh_pkg::ST_T3:
                    mix_reg <= mix_reg + lmh_pkg::rotl32(lane_reg[1], 5'd10) + prior_reg;
                lmh_pkg::ST_T4:
                    lane_reg[1] <= lane_reg[1] + (tail_w1 & mask1) + mix_reg
                                 + lmh_pkg::LANE_CONST[{1'b0, tail_rest} + 3'd3];
                lmh_pkg::ST_FA:
                begin
                    lane_reg[0] <= lane_reg[0] + prior_reg;
                    mix_reg     <= mix_reg
                                 + lmh_pkg::rotl32(lane_reg[0] + prior_reg, 5'd8);
                end
                lmh_pkg::ST_FB:
                begin
                    lane_reg[1] <= lane_reg[1] + (prior_reg ^ mix_reg);
                    mix_reg     <= mix_reg
                                 + lmh_pkg::rotl32(lane_reg[1] + (prior_reg ^ mix_reg), 5'd9);
                end
                lmh_pkg::ST_FC:
                begin
                    lane_reg[2] <= lane_reg[2] + prior_reg + mix_reg;
                    mix_reg     <= mix_reg
                                 + lmh_pkg::rotl32(lane_reg[2] + prior_reg + mix_reg, 5'd10);
                end
                lmh_pkg::ST_FD:
                begin
                    lane_reg[3] <= lane_reg[3] + mix_reg;
                    mix_reg     <= mix_reg + lmh_pkg::rotl32(lane_reg[3] + mix_reg, 5'd11);
                end
                lmh_pkg::ST_FE:
                begin
                    lane_reg[4] <= lane_reg[4] + mix_reg;
                    mix_reg     <= mix_reg + lmh_pkg::rotl32(lane_reg[4] + mix_reg, 5'd12);
                end
                lmh_pkg::ST_FF:
                begin
                    lane_reg[5] <= lane_reg[5] + mix_reg;
                    mix_reg     <= mix_reg + lmh_pkg::rotl32(lane_reg[5] + mix_reg, 5'd13);
                end
                lmh_pkg::ST_FG:
                begin
                    lane_reg[6] <= lane_reg[6] + mix_reg;
                    mix_reg     <= mix_reg + lmh_pkg::rotl32(lane_reg[6] + mix_reg, 5'd14);
                end
                lmh_pkg::ST_FH:
                begin
                    lane_reg[7] <= lane_reg[7] + lane_reg[0] + mix_reg;
                    mix_reg     <= mix_reg + prior_reg + lmh_pkg::rotl32(
                                   lane_reg[7] + lane_reg[0] + mix_reg, 5'd15);
                end
                lmh_pkg::ST_G0:
                    prior_reg <= prior_reg + mix_reg + job_reg.total;
                lmh_pkg::ST_G1:
                    mix_reg <= mix_reg + (lmh_pkg::rotl32(lane_reg[0], 5'd13) ^ lane_reg[7]);
                lmh_pkg::ST_G2:
                begin
                    lane_reg[1] <= lane_reg[1] + mix_reg;
                    mix_reg     <= mix_reg + (lane_reg[0]
                                 ^ lmh_pkg::rotl32(lane_reg[1] + mix_reg, 5'd14));
                end
                lmh_pkg::ST_G3:
                begin
                    lane_reg[2] <= lane_reg[2] + (prior_reg ^ mix_reg);
                    mix_reg     <= mix_reg + (lane_reg[1] ^ lmh_pkg::rotl32(
                                   lane_reg[2] + (prior_reg ^ mix_reg), 5'd15));
                end
                lmh_pkg::ST_G4:
                begin
                    lane_reg[3] <= lane_reg[3] + prior_reg + mix_reg;
                    mix_reg     <= mix_reg + (lane_reg[2] ^ lmh_pkg::rotl32(
                                   lane_reg[3] + prior_reg + mix_reg, 5'd17));
                end
                lmh_pkg::ST_G5:
                    prior_reg <= prior_reg + mix_reg;
                lmh_pkg::ST_G6:
                begin
                    lane_reg[4] <= lane_reg[4] + (prior_reg ^ mix_reg);
                    mix_reg     <= mix_reg + (lane_reg[3] ^ lmh_pkg::rotl32(
                                   lane_reg[4] + (prior_reg ^ mix_reg), 5'd18));
                end
                lmh_pkg::ST_G7:
                begin
                    lane_reg[5] <= lane_reg[5] + prior_reg + mix_reg;
                    mix_reg     <= mix_reg + (lane_reg[4] ^ lmh_pkg::rotl32(
                                   lane_reg[5] + prior_reg + mix_reg, 5'd19));
                end
                lmh_pkg::ST_G8:
                begin
                    lane_reg[6] <= lane_reg[6] + mix_reg;
                    mix_reg     <= mix_reg + (lane_reg[5]
                                 ^ lmh_pkg::rotl32(lane_reg[6] + mix_reg, 5'd20));
                end
                lmh_pkg::ST_G9:
                    lane_reg[7] <= lane_reg[7] + mix_reg;
                lmh_pkg::ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        for (int i = 0; i < lmh_pkg::LANES; i++)
                            lane_reg[i] <= lmh_pkg::LANE_CONST[i];
                        mix_reg   <= lmh_pkg::MIX_INIT;
                        prior_reg <= lmh_pkg::PRIOR_INIT;
                    end
                end
                default:
                begin
                    acc_reg <= '0;
                    k_reg   <= '0;
                end
            endcase
        end
    end

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (mix_reg == lmh_pkg::MIX_INIT && prior_reg == lmh_pkg::PRIOR_INIT
                     && lane_reg[7] == lmh_pkg::LANE_CONST[7]))
        else $error("engine state not reinitialized after hash");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmh_pkg::ST_SUM) |-> (k_reg <= sum_last))
        else $error("lane sum index out of range");

endmodule

>>> src/lane_mix_hash_32_top.sv
// lane_mix_hash_32_top: byte-serial 32-bit message hash
// byte_ch carries one message byte per transfer (has_byte = 1) or an empty
// marker (has_byte = 0); last = 1 closes the message and requests its hash.
// hash_ch carries one 32-bit hash_value per message, in message order.
// bytes are taken at one per cycle; ready drops only when the job queue
// between the byte collector and the mixing engine is full.
// every 32nd byte hands a block to the engine: after the hand-off, one
// lane per cycle for the sum and again for the lane update, overlapped
// with collecting the next block.
// a message end runs the engine through leftover chunks, tail and
// finalization rounds, one dependent step per cycle; the hash appears
// on hash_ch after these rounds and any queue wait.
// reset clears the collector, the queue and the output register and loads
// the lane and mixing words with their initial constants; no clearing pass.
// if the receiver stalls, the hash waits in the output register; the engine
// holds its next result and the queue absorbs later work until it fills.
module lane_mix_hash_32_top #(
    parameter int unsigned QUEUE_DEPTH = lmh_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    lmh_in_if.sink     byte_ch,
    lmh_out_if.source  hash_ch
);

    // collector to queue
    logic          push;
    lmh_pkg::job_t push_job;
    logic          q_full;

    // queue to engine
    logic          pop;
    logic          q_valid;
    lmh_pkg::job_t q_job;

    // front: gathers bytes into the block buffer, emits block and end jobs
    lmh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // short job queue so the collector keeps taking bytes while mixing runs
    lmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // back: lane mixing, chunk and tail handling, finalization, output register
    lmh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .hash_ch (hash_ch)
    );

endmodule
